// ===== hw/rtl/bid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bid_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_KERNEL  = 15;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CNT_W  = 9;
  localparam int KER_W  = 4;
  localparam int HALF_W = 3;
  localparam int PASS_W = 8;
  localparam int WIN_W  = MAX_KERNEL;

  typedef enum logic [1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLUMNS = 2'd1,
    CFG_KERNEL  = 2'd2,
    CFG_PASSES  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HSWEEP,
    ST_HDRAIN,
    ST_VSWEEP,
    ST_VDRAIN,
    ST_DONE
  } eng_state_e;

  // Effective geometry after saturation and odd rounding of the kernel.
  typedef struct packed {
    logic [CNT_W-1:0]  nr;
    logic [CNT_W-1:0]  nc;
    logic [KER_W-1:0]  k;
    logic [HALF_W-1:0] h;
    logic [PASS_W-1:0] passes;
  } geom_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Maps a coordinate onto the interior band [h, n-h-1]; border pixels
  // always equal their nearest interior pixel.
  function automatic logic [ROW_W-1:0] clamp_coord(input logic [ROW_W-1:0] x,
                                                  input logic [HALF_W-1:0] h,
                                                  input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] hi;
    logic [ROW_W-1:0] res;
    hi = n - CNT_W'(h) - CNT_W'(1);
    if (x < ROW_W'(h)) begin
      res = ROW_W'(h);
    end else if (CNT_W'(x) > hi) begin
      res = hi[ROW_W-1:0];
    end else begin
      res = x;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/binary_image_dilation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Binary image dilation with a square, odd kernel.
//
// Items arrive on start/busy: one is taken at a clock edge where start is
// high and busy is low. mode_i = 0 stores pixel_in_i at (row_i, column_i)
// and gives no result; mode_i = 1 reads a result pixel, which appears on
// pixel_out_o with valid_o high for exactly one cycle. The receiver cannot
// hold results off, so nothing ever stalls on the output side.
// A load is written when accepted and a read of a ready result shows its
// pixel in the next cycle, so loads and reads stream at one item per cycle
// while busy stays low, limited by each image memory's single read port.
// The first read after a load or a configuration write runs the dilation
// passes first: each pass is a horizontal sweep over every row, then a
// vertical sweep over columns h to columns-h-1 (h is half the kernel), each
// followed by its drain state; the pixel is read after the last pass.
// Border pixels of the result are never stored: writes land only on the
// interior, and every read of the result image is clamped onto it.
// Reset clears the result flag and restores the default configuration; the
// image memories are not cleared, and an unloaded pixel reads undefined. The
// user must write configuration via cfg_we_i when idle; it is not enforced.
module binary_image_dilation (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       mode_i,
  input  wire logic [7:0] row_i,
  input  wire logic [7:0] column_i,
  input  wire logic       pixel_in_i,
  output logic            valid_o,
  output logic            pixel_out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [8:0] cfg_data_i
);
  import bid_pkg::*;

  logic [CNT_W-1:0]  rows_q, cols_q;
  logic [KER_W-1:0]  ker_q;
  logic [PASS_W-1:0] passes_q;
  logic              ready_q, ready_d;
  geom_t             geom;
  logic              undersized;
  logic              accept, need_calc, rd_now, rd_go;
  logic [ROW_W-1:0]  pend_r_q, pend_c_q, rd_r, rd_c;
  logic              out_vld_q, out_zero_q, out_src_q;

  logic              eng_busy, eng_done;
  logic [ADDR_W-1:0] eng_src_raddr;
  ram_req_t          a_req, b_req;
  logic              src_rdata, a_rdata, b_rdata;

  // Counts saturate at the memory size; the kernel is forced odd.
  always_comb begin
    geom.nr     = (rows_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_q;
    geom.nc     = (cols_q > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : cols_q;
    geom.k      = ker_q | KER_W'(1);
    geom.h      = geom.k[KER_W-1:1];
    geom.passes = passes_q;
  end

  // With passes enabled an image smaller than the kernel dilates to zero.
  assign undersized = (passes_q != '0) &&
                      ((geom.nr < CNT_W'(geom.k)) || (geom.nc < CNT_W'(geom.k)));

  assign busy      = eng_busy;
  assign accept    = start && !busy;
  assign need_calc = !ready_q && (passes_q != '0) && !undersized;
  assign rd_now    = accept && mode_i && !need_calc;
  assign rd_go     = rd_now || eng_done;
  assign rd_r      = rd_now ? row_i : pend_r_q;
  assign rd_c      = rd_now ? column_i : pend_c_q;

  always_comb begin
    ready_d = ready_q;
    if (accept) begin
      ready_d = mode_i;
    end
    if (cfg_we_i) begin
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q    <= CNT_W'(MAX_ROWS);
      cols_q    <= CNT_W'(MAX_COLUMNS);
      ker_q     <= KER_W'(3);
      passes_q  <= PASS_W'(1);
      ready_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ready_q   <= ready_d;
      out_vld_q <= rd_go;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_ROWS:    rows_q   <= cfg_data_i;
          CFG_COLUMNS: cols_q   <= cfg_data_i;
          CFG_KERNEL:  ker_q    <= cfg_data_i[KER_W-1:0];
          CFG_PASSES:  passes_q <= cfg_data_i[PASS_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_r_q <= row_i;
      pend_c_q <= column_i;
    end
    out_zero_q <= (CNT_W'(rd_r) >= geom.nr) || (CNT_W'(rd_c) >= geom.nc) || undersized;
    out_src_q  <= passes_q == '0;
  end

  bid_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && mode_i && need_calc),
    .geom_i      (geom),
    .src_rdata_i (src_rdata),
    .a_rdata_i   (a_rdata),
    .b_rdata_i   (b_rdata),
    .src_raddr_o (eng_src_raddr),
    .a_req_o     (a_req),
    .b_req_o     (b_req),
    .busy_o      (eng_busy),
    .done_o      (eng_done)
  );

  // Source image: written by loads, read by the first pass or directly.
  bid_ram #(.AW(ADDR_W)) u_src (
    .clk_i   (clk_i),
    .we_i    (accept && !mode_i),
    .waddr_i ({row_i, column_i}),
    .wdata_i (pixel_in_i),
    .raddr_i (rd_go ? {rd_r, rd_c} : eng_src_raddr),
    .rdata_o (src_rdata)
  );

  // Interior result image.
  bid_ram #(.AW(ADDR_W)) u_work_a (
    .clk_i   (clk_i),
    .we_i    (a_req.we),
    .waddr_i (a_req.waddr),
    .wdata_i (a_req.wdata),
    .raddr_i (rd_go ? {clamp_coord(rd_r, geom.h, geom.nr),
                       clamp_coord(rd_c, geom.h, geom.nc)} : a_req.raddr),
    .rdata_o (a_rdata)
  );

  // Row-dilated intermediate image.
  bid_ram #(.AW(ADDR_W)) u_work_b (
    .clk_i   (clk_i),
    .we_i    (b_req.we),
    .waddr_i (b_req.waddr),
    .wdata_i (b_req.wdata),
    .raddr_i (b_req.raddr),
    .rdata_o (b_rdata)
  );

  assign valid_o     = out_vld_q;
  assign pixel_out_o = !out_zero_q && (out_src_q ? src_rdata : a_rdata);

endmodule
`default_nettype wire

// ===== hw/rtl/bid_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bid_ram #(
  parameter int AW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic               rdata_o
);

  logic mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bid_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bid_engine (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire bid_pkg::geom_t   geom_i,
  input  wire logic             src_rdata_i,
  input  wire logic             a_rdata_i,
  input  wire logic             b_rdata_i,
  output logic [bid_pkg::ADDR_W-1:0] src_raddr_o,
  output bid_pkg::ram_req_t     a_req_o,
  output bid_pkg::ram_req_t     b_req_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import bid_pkg::*;

  eng_state_e state_q, state_d;
  logic [ROW_W-1:0]  ca_q, ca_d, cb_q, cb_d;
  logic [PASS_W-1:0] left_q, left_d;
  logic              first_q, first_d;
  logic              last_a, last_b;

  logic              p_vld_q, p_h_q, p_src_q;
  logic [ROW_W-1:0]  p_a_q, p_b_q;
  logic [WIN_W-2:0]  sh_q;
  logic              bit_in, orv, wen;
  logic [WIN_W-1:0]  win, mask;
  logic [15:0]       m16;
  logic [ROW_W-1:0]  p_pos;

  always_comb begin
    last_a = 1'b0;
    last_b = 1'b0;
    if (state_q == ST_VSWEEP) begin
      last_a = CNT_W'(ca_q) == geom_i.nr - CNT_W'(1);
      last_b = CNT_W'(cb_q) == geom_i.nc - CNT_W'(geom_i.h) - CNT_W'(1);
    end else begin
      last_a = CNT_W'(ca_q) == geom_i.nc - CNT_W'(1);
      last_b = CNT_W'(cb_q) == geom_i.nr - CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_HSWEEP;
      ST_HSWEEP: if (last_a && last_b) state_d = ST_HDRAIN;
      ST_HDRAIN: state_d = ST_VSWEEP;
      ST_VSWEEP: if (last_a && last_b) state_d = ST_VDRAIN;
      ST_VDRAIN: state_d = (left_q == PASS_W'(1)) ? ST_DONE : ST_HSWEEP;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ca_d    = ca_q;
    cb_d    = cb_q;
    left_d  = left_q;
    first_d = first_q;
    unique case (state_q)
      ST_IDLE: begin
        ca_d    = '0;
        cb_d    = '0;
        left_d  = geom_i.passes;
        first_d = 1'b1;
      end
      ST_HSWEEP, ST_VSWEEP: begin
        if (last_a) begin
          ca_d = '0;
          cb_d = cb_q + ROW_W'(1);
        end else begin
          ca_d = ca_q + ROW_W'(1);
        end
      end
      ST_HDRAIN: begin
        ca_d = '0;
        cb_d = ROW_W'(geom_i.h);
      end
      ST_VDRAIN: begin
        ca_d    = '0;
        cb_d    = '0;
        left_d  = left_q - PASS_W'(1);
        first_d = 1'b0;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Horizontal sweep reads the source on the first pass, else the previous result through the border clamp.
  assign src_raddr_o   = {cb_q, ca_q};
  assign a_req_o.raddr = {clamp_coord(cb_q, geom_i.h, geom_i.nr),
                          clamp_coord(ca_q, geom_i.h, geom_i.nc)};
  assign b_req_o.raddr = {ca_q, cb_q};

  // Sliding window over the read stream.
  assign bit_in = p_h_q ? (p_src_q ? src_rdata_i : a_rdata_i) : b_rdata_i;
  assign win    = {(p_a_q == '0) ? {(WIN_W-1){1'b0}} : sh_q, bit_in};
  assign m16    = (16'd1 << geom_i.k) - 16'd1;
  assign mask   = m16[WIN_W-1:0];
  assign orv    = |(win & mask);
  assign wen    = p_vld_q && (CNT_W'(p_a_q) >= CNT_W'(geom_i.k) - CNT_W'(1));
  assign p_pos  = p_a_q - ROW_W'(geom_i.h);

  assign b_req_o.we    = wen && p_h_q;
  assign b_req_o.waddr = {p_b_q, p_pos};
  assign b_req_o.wdata = orv;
  assign a_req_o.we    = wen && !p_h_q;
  assign a_req_o.waddr = {p_pos, p_b_q};
  assign a_req_o.wdata = orv;

  assign busy_o = state_q != ST_IDLE;
  assign done_o = state_q == ST_DONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      p_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p_vld_q <= (state_q == ST_HSWEEP) || (state_q == ST_VSWEEP);
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q    <= ca_d;
    cb_q    <= cb_d;
    left_q  <= left_d;
    first_q <= first_d;
    p_h_q   <= state_q == ST_HSWEEP;
    p_src_q <= first_q;
    p_a_q   <= ca_q;
    p_b_q   <= cb_q;
    if (p_vld_q) begin
      sh_q <= win[WIN_W-2:0];
    end
  end

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(a_req_o.we && b_req_o.we)) else $error("both work images written at once");
  a_done_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> $past(state_q) == ST_VDRAIN) else $error("done without drain");
  a_b_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_req_o.we |-> (state_q == ST_HSWEEP || state_q == ST_HDRAIN))
    else $error("row buffer written outside horizontal sweep");

endmodule
`default_nettype wire
